// ----- rtl/core/ffpa_pkg.sv -----
// ffpa_pkg: shared constants, codes and types of the first-fit partition allocator.
// Used by ffpa_run_unit and first_fit_partition_allocator.
// No dependencies.
package ffpa_pkg;

    localparam int MEM_UNITS_DEF = 1024;
    localparam int MAX_TASKS_DEF = 32;

    localparam int CMD_W    = 1;
    localparam int SIZE_W   = 11;
    localparam int TID_W    = 5;
    localparam int STATUS_W = 2;
    localparam int BASE_W   = 10;

    localparam int S_DATA_W = 24;
    localparam int M_DATA_W = 24;

    localparam logic [CMD_W-1:0] CMD_ADD = 1'b0;
    localparam logic [CMD_W-1:0] CMD_DEL = 1'b1;

    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NO_ID    = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NO_SPACE = 2'd2;
    localparam logic [STATUS_W-1:0] ST_BAD_SIZE = 2'd3;

    typedef struct packed {
        logic clear;
        logic step;
        logic unit_free;
    } run_ctl_t;

endpackage

// ----- rtl/core/ffpa_unit_ram.sv -----
// ffpa_unit_ram: unit map storage, one write port and one registered read port.
// Entry is {busy, owner}. Depends on nothing.
module ffpa_unit_ram #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 6
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- rtl/core/ffpa_run_unit.sv -----
// ffpa_run_unit: free-run length counter and size compare used during the add scan.
// Depends on ffpa_pkg (run_ctl_t).
module ffpa_run_unit #(
    parameter int MEM_UNITS = ffpa_pkg::MEM_UNITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  ffpa_pkg::run_ctl_t            ctl,
    input  logic [$clog2(MEM_UNITS)-1:0]  unit_addr,
    input  logic [$clog2(MEM_UNITS+1)-1:0] size,
    output logic                          hit,
    output logic [$clog2(MEM_UNITS)-1:0]  hit_base
);

    localparam int AW = $clog2(MEM_UNITS);
    localparam int CW = $clog2(MEM_UNITS + 1);

    logic [CW-1:0] run_reg, run_next;
    logic [AW-1:0] start_reg, start_next;
    logic [CW-1:0] run_inc;

    assign run_inc  = run_reg + CW'(1);
    assign hit      = ctl.step && ctl.unit_free && (run_inc == size);
    assign hit_base = (run_reg == '0) ? unit_addr : start_reg;

    always_comb
    begin
        run_next   = run_reg;
        start_next = start_reg;
        if (ctl.clear)
        begin
            run_next = '0;
        end
        else if (ctl.step)
        begin
            if (!ctl.unit_free)
            begin
                run_next = '0;
            end
            else
            begin
                run_next = run_inc;
                if (run_reg == '0)
                begin
                    start_next = unit_addr;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg <= '0;
        end
        else
        begin
            run_reg <= run_next;
        end
    end

    always_ff @(posedge clk)
    begin
        start_reg <= start_next;
    end

endmodule

// ----- rtl/core/first_fit_partition_allocator.sv -----
// first_fit_partition_allocator: first-fit allocator over a unit map with task ids.
// Depends on ffpa_pkg, ffpa_unit_ram, ffpa_run_unit.
//
//   channel  | dir | payload (tdata, lowest bit first)
//   ---------+-----+--------------------------------------------------
//   s_axis   | in  | cmd[0], request_size[11:1], target_id[16:12]
//   m_axis   | out | status[1:0], assigned_id[6:2], base_unit[16:7]
//
// After reset a clearing pass writes every map entry; no beat is taken meanwhile.
// An add scans the map for the first free run of size units and then fills it;
// a delete scans the whole map. Both scans go through the single read port of
// the unit map, one unit per cycle. Early rejects skip the scan.
// A result waiting in the output register stalls only the finish of the next item.
module first_fit_partition_allocator #(
    parameter int MEM_UNITS = ffpa_pkg::MEM_UNITS_DEF,
    parameter int MAX_TASKS = ffpa_pkg::MAX_TASKS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [ffpa_pkg::S_DATA_W-1:0] s_tdata,  // cmd, request_size, target_id
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [ffpa_pkg::M_DATA_W-1:0] m_tdata   // status, assigned_id, base_unit
);

    localparam int AW   = $clog2(MEM_UNITS);
    localparam int CW   = $clog2(MEM_UNITS + 1);
    localparam int IDW  = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
    localparam int ENTW = IDW + 1;
    localparam int CMPW = (CW > ffpa_pkg::SIZE_W) ? CW : ffpa_pkg::SIZE_W;

    typedef enum logic [5:0] {
        S_CLEAR    = 6'b000001,
        S_IDLE     = 6'b000010,
        S_ADD_SCAN = 6'b000100,
        S_ADD_FILL = 6'b001000,
        S_DEL_SCAN = 6'b010000,
        S_DONE     = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    logic [CW-1:0]        cnt_reg, cnt_next;
    logic                 pv_reg, pv_next;
    logic [AW-1:0]        pa_reg, pa_next;
    logic [MAX_TASKS-1:0] mask_reg, mask_next;
    logic                 m_valid_reg, m_valid_next;

    logic [IDW-1:0]                  id_reg, id_next;
    logic [IDW-1:0]                  target_reg, target_next;
    logic [CW-1:0]                   size_reg, size_next;
    logic [AW-1:0]                   fill_addr_reg, fill_addr_next;
    logic [CW-1:0]                   left_reg, left_next;
    logic [ffpa_pkg::STATUS_W-1:0]   res_status_reg, res_status_next;
    logic [ffpa_pkg::TID_W-1:0]      res_id_reg, res_id_next;
    logic [ffpa_pkg::BASE_W-1:0]     res_base_reg, res_base_next;
    logic [ffpa_pkg::M_DATA_W-1:0]   m_data_reg, m_data_next;

    logic [ffpa_pkg::CMD_W-1:0]  in_cmd;
    logic [ffpa_pkg::SIZE_W-1:0] in_size;
    logic [ffpa_pkg::TID_W-1:0]  in_target;

    logic            ram_we;
    logic [AW-1:0]   ram_waddr;
    logic [ENTW-1:0] ram_wdata;
    logic [AW-1:0]   ram_raddr;
    logic [ENTW-1:0] ram_rdata;

    ffpa_pkg::run_ctl_t run_ctl;
    logic               run_hit;
    logic [AW-1:0]      run_base;

    logic            any_free;
    logic [IDW-1:0]  free_id;
    logic            issue;
    logic            accept;
    logic            last_unit;

    assign in_cmd    = s_tdata[0];
    assign in_size   = s_tdata[11:1];
    assign in_target = s_tdata[16:12];

    assign s_tready = (state_reg == S_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    assign issue     = (cnt_reg != CW'(MEM_UNITS));
    assign ram_raddr = cnt_reg[AW-1:0];
    assign last_unit = pv_reg && (pa_reg == AW'(MEM_UNITS - 1));

    always_comb
    begin
        any_free = 1'b0;
        free_id  = '0;
        for (int i = MAX_TASKS - 1; i >= 0; i--)
        begin
            if (mask_reg[i])
            begin
                any_free = 1'b1;
                free_id  = IDW'(i);
            end
        end
    end

    ffpa_unit_ram #(
        .DEPTH (MEM_UNITS),
        .WIDTH (ENTW)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    ffpa_run_unit #(
        .MEM_UNITS (MEM_UNITS)
    ) u_run (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (run_ctl),
        .unit_addr (pa_reg),
        .size      (size_reg),
        .hit       (run_hit),
        .hit_base  (run_base)
    );

    always_comb
    begin
        state_next      = state_reg;
        cnt_next        = cnt_reg;
        pv_next         = 1'b0;
        pa_next         = ram_raddr;
        mask_next       = mask_reg;
        m_valid_next    = m_valid_reg && !m_tready;
        id_next         = id_reg;
        target_next     = target_reg;
        size_next       = size_reg;
        fill_addr_next  = fill_addr_reg;
        left_next       = left_reg;
        res_status_next = res_status_reg;
        res_id_next     = res_id_reg;
        res_base_next   = res_base_reg;
        m_data_next     = m_data_reg;
        ram_we          = 1'b0;
        ram_waddr       = pa_reg;
        ram_wdata       = '0;
        run_ctl.clear     = 1'b0;
        run_ctl.step      = 1'b0;
        run_ctl.unit_free = !ram_rdata[ENTW-1];

        case (state_reg)
            S_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = cnt_reg[AW-1:0];
                cnt_next  = cnt_reg + CW'(1);
                if (cnt_reg == CW'(MEM_UNITS - 1))
                begin
                    state_next = S_IDLE;
                end
            end

            S_IDLE:
            begin
                if (accept)
                begin
                    res_status_next = ffpa_pkg::ST_OK;
                    res_id_next     = '0;
                    res_base_next   = '0;
                    cnt_next        = '0;
                    run_ctl.clear   = 1'b1;
                    target_next     = IDW'(in_target);
                    size_next       = CW'(in_size);
                    id_next         = free_id;
                    if (in_cmd == ffpa_pkg::CMD_DEL)
                    begin
                        if (32'(in_target) < MAX_TASKS)
                        begin
                            state_next = S_DEL_SCAN;
                        end
                        else
                        begin
                            state_next = S_DONE;
                        end
                    end
                    else if (!any_free)
                    begin
                        res_status_next = ffpa_pkg::ST_NO_ID;
                        state_next      = S_DONE;
                    end
                    else if (in_size == '0)
                    begin
                        res_status_next = ffpa_pkg::ST_BAD_SIZE;
                        state_next      = S_DONE;
                    end
                    else if (CMPW'(in_size) > CMPW'(MEM_UNITS))
                    begin
                        res_status_next = ffpa_pkg::ST_NO_SPACE;
                        state_next      = S_DONE;
                    end
                    else
                    begin
                        state_next = S_ADD_SCAN;
                    end
                end
            end

            S_ADD_SCAN:
            begin
                run_ctl.step = pv_reg;
                if (run_hit)
                begin
                    fill_addr_next = run_base;
                    left_next      = size_reg;
                    res_base_next  = ffpa_pkg::BASE_W'(run_base);
                    state_next     = S_ADD_FILL;
                end
                else if (last_unit)
                begin
                    res_status_next = ffpa_pkg::ST_NO_SPACE;
                    state_next      = S_DONE;
                end
                else if (issue)
                begin
                    pv_next  = 1'b1;
                    cnt_next = cnt_reg + CW'(1);
                end
            end

            S_ADD_FILL:
            begin
                ram_we         = 1'b1;
                ram_waddr      = fill_addr_reg;
                ram_wdata      = {1'b1, id_reg};
                fill_addr_next = fill_addr_reg + AW'(1);
                left_next      = left_reg - CW'(1);
                if (left_reg == CW'(1))
                begin
                    mask_next[id_reg] = 1'b0;
                    res_id_next       = ffpa_pkg::TID_W'(id_reg);
                    state_next        = S_DONE;
                end
            end

            S_DEL_SCAN:
            begin
                if (pv_reg && ram_rdata[ENTW-1] && (ram_rdata[IDW-1:0] == target_reg))
                begin
                    ram_we    = 1'b1;
                    ram_waddr = pa_reg;
                    ram_wdata = {1'b0, ram_rdata[IDW-1:0]};
                end
                if (last_unit)
                begin
                    mask_next[target_reg] = 1'b1;
                    state_next            = S_DONE;
                end
                else if (issue)
                begin
                    pv_next  = 1'b1;
                    cnt_next = cnt_reg + CW'(1);
                end
            end

            S_DONE:
            begin
                if (!m_valid_reg || m_tready)
                begin
                    m_valid_next = 1'b1;
                    m_data_next  = ffpa_pkg::M_DATA_W'({res_base_reg, res_id_reg,
                                                        res_status_reg});
                    state_next   = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_CLEAR;
            cnt_reg     <= '0;
            pv_reg      <= 1'b0;
            mask_reg    <= '1;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            pv_reg      <= pv_next;
            mask_reg    <= mask_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pa_reg         <= pa_next;
        id_reg         <= id_next;
        target_reg     <= target_next;
        size_reg       <= size_next;
        fill_addr_reg  <= fill_addr_next;
        left_reg       <= left_next;
        res_status_reg <= res_status_next;
        res_id_reg     <= res_id_next;
        res_base_reg   <= res_base_next;
        m_data_reg     <= m_data_next;
    end

endmodule

// ----- tb/testbench.sv -----
// testbench: self-checking bench for first_fit_partition_allocator.
// Drives add and delete requests as stream beats and checks each result against a
// built-in first-fit predictor or a typed expectation. Depends on ffpa_pkg and the allocator RTL.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MEM         = ffpa_pkg::MEM_UNITS_DEF;
    localparam int TASKS       = ffpa_pkg::MAX_TASKS_DEF;
    localparam int STALL_LIMIT = 20 * MEM;
    localparam int TAIL_CYCLES = 2 * MEM + 32;
    localparam int PLAN_ROWS   = 21;

    typedef struct packed {
        logic [ffpa_pkg::STATUS_W-1:0] status;
        logic [ffpa_pkg::TID_W-1:0]    id;
        logic [ffpa_pkg::BASE_W-1:0]   base;
    } alloc_result_t;

    typedef struct {
        logic [ffpa_pkg::CMD_W-1:0] cmd;
        int                         size;
        int                         tgt;
        int                         reps;
        bit                         fixed;
        alloc_result_t              want;
    } plan_row_t;

    logic                          clk = 1'b0;
    logic                          rst_n = 1'b0;
    logic                          s_tvalid = 1'b0;
    logic                          s_tready;
    logic [ffpa_pkg::S_DATA_W-1:0] s_tdata = '0;
    logic                          m_tvalid;
    logic                          m_tready = 1'b0;
    logic [ffpa_pkg::M_DATA_W-1:0] m_tdata;

    // predictor state
    bit                         unit_taken [MEM];
    logic [ffpa_pkg::TID_W-1:0] unit_tag [MEM];
    logic [TASKS-1:0]           ids_free;

    alloc_result_t pending_q [$];
    int            errors = 0;
    bit            send_idle = 1'b1;
    int            rcv_hold = 0;
    int            rcv_beats = 0;
    int            quiet_cycles = 0;
    plan_row_t     plan [PLAN_ROWS];

    first_fit_partition_allocator DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),   // cmd, request_size, target_id
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)    // status, assigned_id, base_unit
    );

    always #4 clk = ~clk;

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("%0t: MISMATCH %s got %0d expected %0d", $realtime, what, got, want);
        errors++;
    endtask

    function automatic alloc_result_t predict_request(
        input logic [ffpa_pkg::CMD_W-1:0]  cmd,
        input logic [ffpa_pkg::SIZE_W-1:0] size,
        input logic [ffpa_pkg::TID_W-1:0]  tgt
    );
        alloc_result_t r;
        int            sz;
        int            pick;
        int            run;
        int            start;
        bit            placed;
        r      = '{ffpa_pkg::ST_OK, '0, '0};
        sz     = int'(size);
        pick   = -1;
        run    = 0;
        start  = 0;
        placed = 1'b0;
        if (cmd == ffpa_pkg::CMD_DEL)
        begin
            for (int u = 0; u < MEM; u++)
            begin
                if (unit_taken[u] && unit_tag[u] == tgt)
                begin
                    unit_taken[u] = 1'b0;
                end
            end
            ids_free[tgt] = 1'b1;
            return r;
        end
        for (int i = 0; i < TASKS; i++)
        begin
            if (ids_free[i])
            begin
                pick = i;
                break;
            end
        end
        if (pick < 0)
        begin
            r.status = ffpa_pkg::ST_NO_ID;
            return r;
        end
        if (sz == 0)
        begin
            r.status = ffpa_pkg::ST_BAD_SIZE;
            return r;
        end
        if (sz > MEM)
        begin
            r.status = ffpa_pkg::ST_NO_SPACE;
            return r;
        end
        for (int u = 0; u < MEM; u++)
        begin
            if (unit_taken[u])
            begin
                run = 0;
            end
            else
            begin
                run++;
                if (run == sz)
                begin
                    start  = u + 1 - sz;
                    placed = 1'b1;
                    break;
                end
            end
        end
        if (!placed)
        begin
            r.status = ffpa_pkg::ST_NO_SPACE;
            return r;
        end
        for (int u = start; u < start + sz; u++)
        begin
            unit_taken[u] = 1'b1;
            unit_tag[u]   = pick[ffpa_pkg::TID_W-1:0];
        end
        ids_free[pick] = 1'b0;
        r.id   = pick[ffpa_pkg::TID_W-1:0];
        r.base = start[ffpa_pkg::BASE_W-1:0];
        return r;
    endfunction

    // one request beat; a typed expectation overrides the predicted one
    task automatic send_req(input logic [ffpa_pkg::CMD_W-1:0] cmd, input int size,
                            input int tgt, input bit fixed, input alloc_result_t want);
        int            gap;
        alloc_result_t pred;
        gap = send_idle ? $urandom_range(0, 18) : 0;
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {7'd0, tgt[ffpa_pkg::TID_W-1:0], size[ffpa_pkg::SIZE_W-1:0], cmd};
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        pred = predict_request(cmd, size[ffpa_pkg::SIZE_W-1:0], tgt[ffpa_pkg::TID_W-1:0]);
        pending_q.push_back(fixed ? want : pred);
    endtask

    task automatic wait_results();
        s_tvalid <= 1'b0;
        while (pending_q.size() != 0) @(negedge clk);
        @(posedge clk);
    endtask

    function automatic int pick_size(input bit filling);
        int r;
        r = $urandom_range(0, 99);
        if (filling)
        begin
            return (r < 90) ? $urandom_range(1, 24) : $urandom_range(100, 400);
        end
        if (r < 5)
        begin
            return 0;
        end
        if (r < 10)
        begin
            return $urandom_range(MEM + 1, 2047);
        end
        if (r < 22)
        begin
            return $urandom_range(200, MEM);
        end
        return $urandom_range(1, 64);
    endfunction

    function automatic int pick_victim();
        int t;
        if (ids_free != '1 && $urandom_range(0, 9) < 8)
        begin
            do
                t = $urandom_range(0, TASKS - 1);
            while (ids_free[t]);
            return t;
        end
        return $urandom_range(0, 31);
    endfunction

    // result checking and receiver stalls
    always @(posedge clk)
    begin
        alloc_result_t exp_r;
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                if (pending_q.size() == 0)
                begin
                    report_mismatch("result beat with nothing pending", int'(m_tdata), 0);
                end
                else
                begin
                    exp_r = pending_q.pop_front();
                    if (m_tdata[1:0] !== exp_r.status)
                    begin
                        report_mismatch("status", int'(m_tdata[1:0]), int'(exp_r.status));
                    end
                    if (m_tdata[6:2] !== exp_r.id)
                    begin
                        report_mismatch("assigned_id", int'(m_tdata[6:2]), int'(exp_r.id));
                    end
                    if (m_tdata[16:7] !== exp_r.base)
                    begin
                        report_mismatch("base_unit", int'(m_tdata[16:7]),
                                        int'(exp_r.base));
                    end
                end
                rcv_beats++;
                rcv_hold = (((rcv_beats / 40) % 3) != 2) ? $urandom_range(0, 18) : 0;
                if (rcv_hold > 0)
                begin
                    m_tready <= 1'b0;
                end
            end
            else if (rcv_hold > 0)
            begin
                rcv_hold--;
                if (rcv_hold == 0)
                begin
                    m_tready <= 1'b1;
                end
            end
            else
            begin
                m_tready <= 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
        begin
            quiet_cycles <= 0;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles == STALL_LIMIT)
        begin
            $display("%0t: no beat moved for %0d cycles", $realtime, STALL_LIMIT);
            $display("testbench NOT OK");
            $finish;
        end
    end

    initial
    begin
        int add_pct;
        plan = '{
            '{ffpa_pkg::CMD_ADD,    0,  0,  1, 1, '{ffpa_pkg::ST_BAD_SIZE, 5'd0, 10'd0}},
            '{ffpa_pkg::CMD_ADD, 2047,  0,  1, 1, '{ffpa_pkg::ST_NO_SPACE, 5'd0, 10'd0}},
            '{ffpa_pkg::CMD_ADD, 1025,  0,  1, 1, '{ffpa_pkg::ST_NO_SPACE, 5'd0, 10'd0}},
            '{ffpa_pkg::CMD_ADD, 1024, 31,  1, 1, '{ffpa_pkg::ST_OK,       5'd0, 10'd0}},
            '{ffpa_pkg::CMD_ADD,    1,  0,  1, 1, '{ffpa_pkg::ST_NO_SPACE, 5'd0, 10'd0}},
            '{ffpa_pkg::CMD_DEL,    0, 31,  1, 1, '{ffpa_pkg::ST_OK,       5'd0, 10'd0}},
            '{ffpa_pkg::CMD_DEL, 2047,  0,  1, 1, '{ffpa_pkg::ST_OK,       5'd0, 10'd0}},
            '{ffpa_pkg::CMD_ADD,    1,  0,  1, 1, '{ffpa_pkg::ST_OK,       5'd0, 10'd0}},
            '{ffpa_pkg::CMD_ADD, 1023,  0,  1, 1, '{ffpa_pkg::ST_OK,       5'd1, 10'd1}},
            '{ffpa_pkg::CMD_DEL,    0,  0,  1, 1, '{ffpa_pkg::ST_OK,       5'd0, 10'd0}},
            '{ffpa_pkg::CMD_ADD,    2,  0,  1, 1, '{ffpa_pkg::ST_NO_SPACE, 5'd0, 10'd0}},
            '{ffpa_pkg::CMD_ADD,    1,  0,  1, 1, '{ffpa_pkg::ST_OK,       5'd0, 10'd0}},
            '{ffpa_pkg::CMD_DEL,    0,  1,  1, 1, '{ffpa_pkg::ST_OK,       5'd0, 10'd0}},
            '{ffpa_pkg::CMD_ADD,  512,  0,  1, 0, '{ffpa_pkg::ST_OK,       5'd0, 10'd0}},
            '{ffpa_pkg::CMD_DEL,    0,  0,  1, 1, '{ffpa_pkg::ST_OK,       5'd0, 10'd0}},
            '{ffpa_pkg::CMD_ADD,    3,  0, 30, 0, '{ffpa_pkg::ST_OK,       5'd0, 10'd0}},
            '{ffpa_pkg::CMD_ADD,   64,  0,  1, 0, '{ffpa_pkg::ST_OK,       5'd0, 10'd0}},
            '{ffpa_pkg::CMD_ADD,    0,  0,  1, 1, '{ffpa_pkg::ST_NO_ID,    5'd0, 10'd0}},
            '{ffpa_pkg::CMD_ADD, 2047,  0,  1, 1, '{ffpa_pkg::ST_NO_ID,    5'd0, 10'd0}},
            '{ffpa_pkg::CMD_DEL,    0, 17,  1, 0, '{ffpa_pkg::ST_OK,       5'd0, 10'd0}},
            '{ffpa_pkg::CMD_ADD,    1,  0,  1, 0, '{ffpa_pkg::ST_OK,       5'd0, 10'd0}}
        };
        for (int u = 0; u < MEM; u++)
        begin
            unit_taken[u] = 1'b0;
            unit_tag[u]   = '0;
        end
        ids_free = '1;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int r = 0; r < PLAN_ROWS; r++)
        begin
            for (int k = 0; k < plan[r].reps; k++)
            begin
                send_req(plan[r].cmd, plan[r].size, plan[r].tgt, plan[r].fixed,
                         plan[r].want);
            end
        end
        wait_results();

        // fill, churn and free phases over a live map
        for (int phase = 0; phase < 11; phase++)
        begin
            send_idle = (phase % 4) != 3;
            add_pct   = (phase % 3 == 0) ? 85 : (phase % 3 == 1) ? 50 : 25;
            for (int k = 0; k < 48; k++)
            begin
                if ($urandom_range(0, 99) < add_pct)
                begin
                    send_req(ffpa_pkg::CMD_ADD, pick_size(phase % 3 == 0),
                             $urandom_range(0, 31), 1'b0, '0);
                end
                else
                begin
                    send_req(ffpa_pkg::CMD_DEL, $urandom_range(0, 2047), pick_victim(),
                             1'b0, '0);
                end
            end
            if (phase % 2 == 1)
            begin
                wait_results();
            end
        end
        wait_results();
        repeat (TAIL_CYCLES) @(posedge clk);

        if (errors == 0 && pending_q.size() == 0)
        begin
            $display("testbench OK");
        end
        else
        begin
            $display("testbench NOT OK");
        end
        $finish;
    end

endmodule
